// ----- hdl/bcd_datetime_to_epoch_macros.svh -----
// assertion macros for the bcd to epoch converter
// no dependencies; included by the top level only
`ifndef BCD_DATETIME_TO_EPOCH_MACROS_SVH
`define BCD_DATETIME_TO_EPOCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define B2E_ASSERT_IMPLY(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
        else $error("b2e assertion failed");

// next-cycle implication, checked outside reset
`define B2E_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
        else $error("b2e assertion failed");

`endif

// ----- hdl/b2e_pkg.sv -----
// shared types, constants and calendar helpers for the bcd to epoch converter
// no dependencies
`default_nettype none

package b2e_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned DAYS_W   = 16;
    localparam int unsigned SOD_W    = 17;

    // range limits of the decoded fields
    localparam logic [7:0] YEAR_MAX  = 8'd100;
    localparam logic [7:0] MONTH_MAX = 8'd12;
    localparam logic [7:0] DAY_MAX   = 8'd31;
    localparam logic [7:0] HOUR_MAX  = 8'd23;
    localparam logic [7:0] MINSEC_MAX = 8'd59;

    // days from 1970-01-01 to 2000-01-01
    localparam logic [DAYS_W-1:0] DAYS_TO_2000 = 16'd10957;
    localparam logic [EPOCH_W-1:0] SEC_PER_DAY = 32'd86400;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = 32'd4133980799;

    // decoded and range checked fields
    typedef struct packed {
        logic       ok;
        logic [6:0] yy;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } b2e_dec_t;

    // day count and partial second-of-day sums
    typedef struct packed {
        logic              ok;
        logic [DAYS_W-1:0] days;
        logic [SOD_W-1:0]  sod_h;
        logic [11:0]       sod_ms;
    } b2e_days_t;

    // scaled day count and full second of day
    typedef struct packed {
        logic               ok;
        logic [EPOCH_W-1:0] prod;
        logic [SOD_W-1:0]   sod;
    } b2e_prod_t;

    // high nibble times ten plus low nibble, no digit check
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        return {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
    endfunction

    // days before the first of the month in a common year
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/b2e_decode.sv -----
// stage one: bcd decode of the six bytes and range check
// depends on b2e_pkg
`default_nettype none

module b2e_decode
    import b2e_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [6*BYTE_W-1:0]  in_data,   // sec, min, hour, day, month, year
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output b2e_dec_t                  out_data
);

    logic [7:0] sec_d, min_d, hour_d, day_d, month_d, yy_d;
    logic       valid_reg;
    b2e_dec_t   data_reg, data_next;

    // decode each byte
    always_comb begin
        sec_d   = bcd_decode(in_data[7:0]);
        min_d   = bcd_decode(in_data[15:8]);
        hour_d  = bcd_decode(in_data[23:16]);
        day_d   = bcd_decode(in_data[31:24]);
        month_d = bcd_decode(in_data[39:32]);
        yy_d    = bcd_decode(in_data[47:40]);
    end

    // range check and narrowing
    always_comb begin
        data_next.ok    = (yy_d <= YEAR_MAX) && (month_d != 8'd0) && (month_d <= MONTH_MAX) &&
                          (day_d != 8'd0) && (day_d <= DAY_MAX) && (hour_d <= HOUR_MAX) &&
                          (min_d <= MINSEC_MAX) && (sec_d <= MINSEC_MAX);
        data_next.yy    = yy_d[6:0];
        data_next.month = month_d[3:0];
        data_next.day   = day_d[4:0];
        data_next.hour  = hour_d[4:0];
        data_next.min   = min_d[5:0];
        data_next.sec   = sec_d[5:0];
    end

    assign in_ready = !valid_reg || out_ready;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/b2e_days.sv -----
// stage two: day count since 1970 and partial second-of-day terms
// depends on b2e_pkg
`default_nettype none

module b2e_days
    import b2e_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire b2e_dec_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output b2e_days_t      out_data
);

    logic              valid_reg;
    b2e_days_t         data_reg, data_next;
    logic [DAYS_W-1:0] year_days;
    logic [DAYS_W-1:0] leap_days;
    logic              leap_adj;

    // 2000 is leap, 2100 is not; year range stops at 2100
    always_comb begin
        leap_days = {9'd0, 7'((in_data.yy + 7'd3) >> 2)};
        year_days = DAYS_TO_2000 + {9'd0, in_data.yy} * 16'd365 + leap_days;
        leap_adj  = (in_data.yy[1:0] == 2'd0) && (in_data.yy != YEAR_MAX[6:0]) &&
                    (in_data.month > 4'd2);
    end

    // day count, day past month end runs on linearly
    always_comb begin
        data_next.ok     = in_data.ok;
        data_next.days   = year_days + {7'd0, days_before_month(in_data.month)} +
                           {15'd0, leap_adj} + {11'd0, in_data.day} - 16'd1;
        data_next.sod_h  = {12'd0, in_data.hour} * 17'd3600;
        data_next.sod_ms = {6'd0, in_data.min} * 12'd60 + {6'd0, in_data.sec};
    end

    assign in_ready = !valid_reg || out_ready;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/b2e_scale.sv -----
// stages three and four: days to seconds, final sum and output register
// depends on b2e_pkg
`default_nettype none

module b2e_scale
    import b2e_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire b2e_days_t     in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [EPOCH_W-1:0] out_epoch,
    output logic               out_ok
);

    logic               mul_valid_reg;
    b2e_prod_t          mul_reg, mul_next;
    logic               mul_ready;
    logic               sum_valid_reg;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               ok_reg;

    // multiply the day count, finish the second of day
    always_comb begin
        mul_next.ok   = in_data.ok;
        mul_next.prod = {16'd0, in_data.days} * SEC_PER_DAY;
        mul_next.sod  = in_data.sod_h + {5'd0, in_data.sod_ms};
    end

    assign mul_ready = !sum_valid_reg || out_ready;
    assign in_ready  = !mul_valid_reg || mul_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (in_ready) begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mul_reg <= mul_next;
        end
    end

    // final add, rejected sets give zero
    assign epoch_next = mul_reg.ok ? (mul_reg.prod + {15'd0, mul_reg.sod}) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_valid_reg && mul_ready) begin
            epoch_reg <= epoch_next;
            ok_reg    <= mul_reg.ok;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_epoch = epoch_reg;
    assign out_ok    = ok_reg;

endmodule

`default_nettype wire

// ----- hdl/bcd_datetime_to_epoch.sv -----
// top level: bcd rtc date and time to unix seconds, four-stage pipeline
// depends on b2e_pkg, b2e_decode, b2e_days, b2e_scale and the macros header
//
// channel  dir  tdata                                       tuser
// s_       in   sec, min, hour, day, month, year (8b each)  none
// m_       out  epoch_seconds (32b)                         valid_res (1b)
//
// one word accepted per cycle, sustained, while m_tready stays high
// four register stages: decode, days, multiply, sum; an accepted word passes through
// them in that order, and m_tvalid rises once the word is held in the sum stage
// the days-to-seconds multiply by 86400 sets the stage depth
// reset clears the stage valid bits only; payload registers are not reset
// a stall holds every full stage; s_tready drops once all four stages are full
`default_nettype none

`include "bcd_datetime_to_epoch_macros.svh"

module bcd_datetime_to_epoch
    import b2e_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [6*BYTE_W-1:0]  s_tdata,   // sec_bcd, min_bcd, hour_bcd, day_bcd,
                                                 // month_bcd, year_bcd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [EPOCH_W-1:0]        m_tdata,   // epoch_seconds
    output logic [0:0]                m_tuser    // valid_res
);

    logic      dec_valid, dec_ready;
    b2e_dec_t  dec_data;
    logic      days_valid, days_ready;
    b2e_days_t days_data;
    logic      res_ok;

    b2e_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    b2e_days u_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (days_valid),
        .out_ready (days_ready),
        .out_data  (days_data)
    );

    b2e_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (days_valid),
        .in_ready  (days_ready),
        .in_data   (days_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_epoch (m_tdata),
        .out_ok    (res_ok)
    );

    assign m_tuser = res_ok;

    // rejected sets come out as zero
    `B2E_ASSERT_IMPLY(a_reject_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0)
    // accepted sets never pass the end of 2100
    `B2E_ASSERT_IMPLY(a_epoch_max, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata <= EPOCH_MAX)
    // an empty output stage leaves the whole pipe open
    `B2E_ASSERT_IMPLY(a_empty_ready, aclk, aresetn, !m_tvalid, s_tready)

endmodule

`default_nettype wire

// ----- verif/b2e_tb_pkg.sv -----
// scoreboard for the bcd date and time to epoch converter testbench
// holds its own calendar arithmetic and the queue of pending epoch words
// depends on b2e_pkg for the byte and epoch widths
package b2e_tb_pkg;
    import b2e_pkg::*;

    // one predicted result word
    typedef struct packed {
        logic [EPOCH_W-1:0] seconds;
        logic               ok;
    } epoch_result_t;

    class epoch_scoreboard;
        epoch_result_t pending_epochs[$];
        int unsigned   sets_in;
        int unsigned   converted_sets;
        int unsigned   rejected_sets;
        int unsigned   mismatches;
        // days before the first of each month in a common year
        int unsigned   month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                           304, 334};

        // weight the high nibble by ten, the low by one, digits unchecked
        function int unsigned nibble_value(logic [7:0] b);
            return int'(b[7:4]) * 10 + int'(b[3:0]);
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        // expected epoch for one packed set of six register bytes
        function epoch_result_t to_epoch(logic [6*BYTE_W-1:0] w);
            int unsigned   sc, mn, hr, dy, mo, yy, days;
            epoch_result_t r;
            sc = nibble_value(w[7:0]);
            mn = nibble_value(w[15:8]);
            hr = nibble_value(w[23:16]);
            dy = nibble_value(w[31:24]);
            mo = nibble_value(w[39:32]);
            yy = nibble_value(w[47:40]);
            r  = '0;
            if (yy > 100 || mo < 1 || mo > 12 || dy < 1 || dy > 31 || hr > 23 ||
                mn > 59 || sc > 59) begin
                return r;
            end
            days = 0;
            for (int unsigned y = 1970; y < 2000 + yy; y++) begin
                days += leap_year(y) ? 366 : 365;
            end
            days += month_start[mo - 1];
            if (mo > 2 && leap_year(2000 + yy)) begin
                days += 1;
            end
            // day past the end of the month just runs on into the next
            days += dy - 1;
            r.seconds = days * 86400 + hr * 3600 + mn * 60 + sc;
            r.ok      = 1'b1;
            return r;
        endfunction

        function void note_word(logic [6*BYTE_W-1:0] w);
            sets_in++;
            pending_epochs.push_back(to_epoch(w));
        endfunction

        // compare one result word with the oldest prediction
        function void check_word(logic [EPOCH_W-1:0] got_seconds, logic got_ok);
            epoch_result_t want;
            if (pending_epochs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: epoch %0d valid %b", got_seconds,
                             got_ok);
                end
                return;
            end
            want = pending_epochs.pop_front();
            if (want.ok) begin
                converted_sets++;
            end else begin
                rejected_sets++;
            end
            if (got_seconds !== want.seconds || got_ok !== want.ok) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: epoch expected %0d got %0d, valid expected %b got %b",
                             want.seconds, got_seconds, want.ok, got_ok);
                end
            end
        endfunction
    endclass

endpackage

// ----- verif/bcd_datetime_to_epoch_tb.sv -----
// testbench top for bcd_datetime_to_epoch: directed corner dates, then random sets
// with random idling on both channels; results checked by epoch_scoreboard
// depends on b2e_pkg, b2e_tb_pkg and the converter rtl
module bcd_datetime_to_epoch_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import b2e_pkg::*;
    import b2e_tb_pkg::*;

    localparam int RANDOM_SETS = 800;
    localparam int CYCLE_LIMIT = 200000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [6*BYTE_W-1:0]  s_tdata;    // sec, min, hour, day, month, year
    logic                 m_tvalid;
    logic                 m_tready;
    logic [EPOCH_W-1:0]   m_tdata;    // epoch_seconds
    logic [0:0]           m_tuser;    // valid_res

    epoch_scoreboard board;
    int                  send_calm;
    int                  recv_calm;
    int unsigned         cycles;

    bcd_datetime_to_epoch dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // idle cycles before the next word, with occasional stretches of none
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [6*BYTE_W-1:0] pack_set(input logic [7:0] yr, mo, dy, hr,
                                                     mn, sc);
        return {yr, mo, dy, hr, mn, sc};
    endfunction

    // bcd byte for v; sometimes spelled with a low nibble above nine
    function automatic logic [7:0] bcd_of(input int unsigned v);
        int unsigned hi, lo;
        hi = v / 10;
        lo = v % 10;
        if (hi > 0 && lo <= 5 && $urandom_range(0, 7) == 0) begin
            hi = hi - 1;
            lo = lo + 10;
        end
        return {hi[3:0], lo[3:0]};
    endfunction

    // value in range, leaning on both ends
    function automatic int unsigned pick(input int unsigned lo, hi);
        case ($urandom_range(0, 9))
            0: begin
                return lo;
            end
            1: begin
                return hi;
            end
            default: begin
                return $urandom_range(lo, hi);
            end
        endcase
    endfunction

    // mostly well-formed dates, some raw noise and some with one field spoiled
    function automatic logic [6*BYTE_W-1:0] random_set();
        logic [7:0] f[6];
        int         roll;
        roll = $urandom_range(0, 99);
        f[0] = bcd_of(pick(0, 59));
        f[1] = bcd_of(pick(0, 59));
        f[2] = bcd_of(pick(0, 23));
        f[3] = bcd_of(pick(1, 31));
        f[4] = bcd_of(pick(1, 12));
        f[5] = bcd_of(pick(0, 100));
        if (roll < 15) begin
            foreach (f[i]) f[i] = 8'($urandom_range(0, 255));
        end else if (roll < 30) begin
            f[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
        end
        return {f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input logic [6*BYTE_W-1:0] w);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        board.note_word(w);
        @(negedge aclk);
    endtask

    // result side: random stalls, every accepted word checked
    initial begin
        m_tready  = 1'b0;
        recv_calm = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            int gap;
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_word(m_tdata, m_tuser[0]);
            @(negedge aclk);
        end
    end

    // stimulus and final report
    initial begin
        board     = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        send_calm = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corner dates: epoch origin of the range, largest value, last second of 2099, rejects
        send_word(pack_set(8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'hA0, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
        send_word(pack_set(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(pack_set(8'h99, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59));
        send_word(pack_set(8'hA1, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00));
        // february 31 in common and leap years, february 29 in 2000 and 2100
        send_word(pack_set(8'h23, 8'h02, 8'h31, 8'h12, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h02, 8'h31, 8'h12, 8'h00, 8'h00));
        send_word(pack_set(8'hA0, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'h00, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00));
        // month, day, hour, minute, second just past range or via hex nibbles
        send_word(pack_set(8'h24, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h0C, 8'h15, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h01, 8'h32, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h01, 8'h1F, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h06, 8'h15, 8'h24, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h06, 8'h15, 8'h1E, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h06, 8'h15, 8'h0F, 8'h00, 8'h00));
        send_word(pack_set(8'h24, 8'h06, 8'h15, 8'h12, 8'h60, 8'h00));
        send_word(pack_set(8'h24, 8'h06, 8'h15, 8'h12, 8'h4F, 8'h5A));
        send_word(pack_set(8'h24, 8'h06, 8'h15, 8'h12, 8'h4F, 8'h4F));
        send_word(pack_set(8'h50, 8'h07, 8'h04, 8'h09, 8'h30, 8'h15));

        for (int i = 0; i < RANDOM_SETS; i++) begin
            send_word(random_set());
        end
        s_tvalid <= 1'b0;

        // drain, then leave room for any stray word
        while (board.pending_epochs.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        $display("%0d date sets sent: %0d converted, %0d rejected by the range check",
                 board.sets_in, board.converted_sets, board.rejected_sets);
        $display("%0d mismatching result words", board.mismatches);
        if (board.mismatches == 0 && board.pending_epochs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
